// ===== rtl/hse_pkg.sv =====
// Package for the heap sort engine: payload types, control word format and microcode program.
`default_nettype none

package hse_pkg;

    // Payload of one input beat
    typedef struct packed {
        logic               mode;
        logic signed [31:0] value;
        logic               last;
    } hse_in_t;

    // Payload of one result beat
    typedef struct packed {
        logic signed [31:0] value_res;
        logic               last_res;
        logic               status;
    } hse_out_t;

    // Input modes and result status codes
    localparam logic MODE_LOAD    = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    // Datapath operation selected by a control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_IDLE,
        OP_REQ_OUT,
        OP_BUILD_INIT,
        OP_BUILD_STEP,
        OP_SIFT_CUR,
        OP_SIFT_CMP,
        OP_SIFT_MOVE,
        OP_EXTRACT_INIT,
        OP_EXTRACT_STEP,
        OP_EXTRACT_SWAP,
        OP_SORT_DONE
    } op_t;

    // Source of read port A address
    typedef enum logic [2:0] {
        A_RDPOS,
        A_NODE,
        A_LCH_NODE,
        A_LCH_BEST,
        A_ZERO
    } asel_t;

    // Source of read port B address
    typedef enum logic [1:0] {
        B_RCH_NODE,
        B_RCH_BEST,
        B_IM1
    } bsel_t;

    // Next-step selection
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_DISPATCH,
        C_OUTWAIT,
        C_IZERO,
        C_ILEONE,
        C_CALL,
        C_DONE_RET
    } cond_t;

    localparam int STEP_W = 4;

    typedef struct packed {
        op_t               op;
        asel_t             asel;
        bsel_t             bsel;
        cond_t             cond;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    // Program addresses
    localparam logic [STEP_W-1:0] ST_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] ST_ROUT   = 4'd1;
    localparam logic [STEP_W-1:0] ST_BINIT  = 4'd2;
    localparam logic [STEP_W-1:0] ST_BSTEP  = 4'd3;
    localparam logic [STEP_W-1:0] ST_BCALL  = 4'd4;
    localparam logic [STEP_W-1:0] ST_BBACK  = 4'd5;
    localparam logic [STEP_W-1:0] ST_SLOAD  = 4'd6;
    localparam logic [STEP_W-1:0] ST_SCUR   = 4'd7;
    localparam logic [STEP_W-1:0] ST_SCMP   = 4'd8;
    localparam logic [STEP_W-1:0] ST_SMOVE  = 4'd9;
    localparam logic [STEP_W-1:0] ST_EINIT  = 4'd10;
    localparam logic [STEP_W-1:0] ST_ESTEP  = 4'd11;
    localparam logic [STEP_W-1:0] ST_ESWAP  = 4'd12;
    localparam logic [STEP_W-1:0] ST_EBACK  = 4'd13;
    localparam logic [STEP_W-1:0] ST_FINISH = 4'd14;

    // Microcode program ROM
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = '{op: OP_NOP, asel: A_RDPOS, bsel: B_RCH_NODE, cond: C_ALWAYS, target: ST_IDLE};
        case (step)
            ST_IDLE:   w = '{OP_IDLE, A_RDPOS, B_RCH_NODE, C_DISPATCH, ST_BINIT};
            ST_ROUT:   w = '{OP_REQ_OUT, A_RDPOS, B_RCH_NODE, C_OUTWAIT, ST_IDLE};
            ST_BINIT:  w = '{OP_BUILD_INIT, A_RDPOS, B_RCH_NODE, C_NEXT, ST_IDLE};
            ST_BSTEP:  w = '{OP_BUILD_STEP, A_RDPOS, B_RCH_NODE, C_IZERO, ST_EINIT};
            ST_BCALL:  w = '{OP_NOP, A_RDPOS, B_RCH_NODE, C_CALL, ST_SLOAD};
            ST_BBACK:  w = '{OP_NOP, A_RDPOS, B_RCH_NODE, C_ALWAYS, ST_BSTEP};
            ST_SLOAD:  w = '{OP_NOP, A_NODE, B_RCH_NODE, C_NEXT, ST_IDLE};
            ST_SCUR:   w = '{OP_SIFT_CUR, A_LCH_NODE, B_RCH_NODE, C_NEXT, ST_IDLE};
            ST_SCMP:   w = '{OP_SIFT_CMP, A_RDPOS, B_RCH_NODE, C_NEXT, ST_IDLE};
            ST_SMOVE:  w = '{OP_SIFT_MOVE, A_LCH_BEST, B_RCH_BEST, C_DONE_RET, ST_SCMP};
            ST_EINIT:  w = '{OP_EXTRACT_INIT, A_RDPOS, B_RCH_NODE, C_NEXT, ST_IDLE};
            ST_ESTEP:  w = '{OP_EXTRACT_STEP, A_ZERO, B_IM1, C_ILEONE, ST_FINISH};
            ST_ESWAP:  w = '{OP_EXTRACT_SWAP, A_LCH_NODE, B_RCH_NODE, C_CALL, ST_SCMP};
            ST_EBACK:  w = '{OP_NOP, A_RDPOS, B_RCH_NODE, C_ALWAYS, ST_ESTEP};
            ST_FINISH: w = '{OP_SORT_DONE, A_RDPOS, B_RCH_NODE, C_ALWAYS, ST_IDLE};
            default:   w = '{OP_NOP, A_RDPOS, B_RCH_NODE, C_ALWAYS, ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/hse_ram.sv =====
// Generic RAM: one write port, two read ports with registered read data.
`default_nettype none

module hse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic      [WIDTH-1:0]         rdata_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and register both reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

`default_nettype wire

// ===== rtl/heap_sort_engine.sv =====
// Heap sort engine top level: microcoded sequencer, sift datapath and element memory.
//
// Usage: feed elements on the item channel with mode 0, one per beat; the beat with
// last set closes the set and starts an in-place heap sort. Loads past DEPTH
// elements are dropped. Each mode 1 beat then returns one result beat with the next
// element in ascending order, last_res marking the final one; a request with no
// element left (or while loading) returns status 1 with value 0.
// A load beat is written to memory in the cycle it is accepted. A request is first
// accepted, then its result is written into the output register once that is free.
// item_ready drops for the whole sort, and after a request until its result is
// written, which waits while the result register is full and the receiver stalls.
// The sort runs on one shared sift-down loop around the element memory (one write,
// two reads per cycle): each heap level is a compare step and a move step, and each
// sift is set up first by the build steps or by the extract steps.
// Reset clears the sequencer, counts and output valid; the element memory needs no
// clearing, since only entries written in the current set are read.
`default_nettype none

module heap_sort_engine #(
    parameter int DEPTH = 1024
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    output logic                 item_ready,
    input  wire hse_pkg::hse_in_t item,
    output logic                 result_valid,
    input  wire logic            result_ready,
    output hse_pkg::hse_out_t    result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = CW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Sequencer state
    logic [hse_pkg::STEP_W-1:0] pc_reg, pc_next;
    logic [hse_pkg::STEP_W-1:0] ret_reg, ret_next;
    hse_pkg::ctrl_t             ctl;

    // Control state
    logic          reading_reg, reading_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] rdpos_reg, rdpos_next;
    logic          out_valid_reg, out_valid_next;

    // Datapath registers
    logic [CW-1:0]      i_reg, i_next;
    logic [CW-1:0]      size_reg, size_next;
    logic [AW-1:0]      node_reg, node_next;
    logic [AW-1:0]      best_reg, best_next;
    logic signed [31:0] cur_reg, cur_next;
    logic [31:0]        bval_reg, bval_next;
    logic               done_reg, done_next;
    logic               empty_reg, empty_next;
    hse_pkg::hse_out_t  out_reg, out_next;

    // Memory ports
    logic          we;
    logic [AW-1:0] waddr;
    logic [31:0]   wdata;
    logic [AW-1:0] raddr_a, raddr_b;
    logic [31:0]   rdata_a, rdata_b;

    // Child indexes and compare terms
    logic [XW-1:0] lch_node, rch_node, lch_best, rch_best;
    logic [CW-1:0] im1, eff_count, rdpos_inc;
    logic          lok, rok, l_gt_cur, r_gt_cur, r_gt_l, take_l, take_r;
    logic          accept, slot_free;

    hse_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_store (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr_a(raddr_a),
        .rdata_a(rdata_a),
        .raddr_b(raddr_b),
        .rdata_b(rdata_b)
    );

    // Fetch the control word
    assign ctl = hse_pkg::ucode(pc_reg);

    assign item_ready   = (ctl.op == hse_pkg::OP_IDLE);
    assign accept       = item_valid && item_ready;
    assign slot_free    = !out_valid_reg || result_ready;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Heap index arithmetic
    assign lch_node  = XW'({node_reg, 1'b1});
    assign rch_node  = XW'({node_reg, 1'b0}) + XW'(2);
    assign lch_best  = XW'({best_reg, 1'b1});
    assign rch_best  = XW'({best_reg, 1'b0}) + XW'(2);
    assign im1       = i_reg - CW'(1);
    assign eff_count = reading_reg ? '0 : count_reg;
    assign rdpos_inc = rdpos_reg + CW'(1);

    // Pick the largest of node and its two children
    assign lok      = lch_node < XW'(size_reg);
    assign rok      = rch_node < XW'(size_reg);
    assign l_gt_cur = $signed(rdata_a) > cur_reg;
    assign r_gt_cur = $signed(rdata_b) > cur_reg;
    assign r_gt_l   = $signed(rdata_b) > $signed(rdata_a);
    assign take_l   = lok && l_gt_cur;
    assign take_r   = rok && (take_l ? r_gt_l : r_gt_cur);

    // Select read addresses
    always_comb
    begin
        case (ctl.asel)
            hse_pkg::A_RDPOS:    raddr_a = rdpos_reg[AW-1:0];
            hse_pkg::A_NODE:     raddr_a = node_reg;
            hse_pkg::A_LCH_NODE: raddr_a = lch_node[AW-1:0];
            hse_pkg::A_LCH_BEST: raddr_a = lch_best[AW-1:0];
            hse_pkg::A_ZERO:     raddr_a = '0;
            default:             raddr_a = '0;
        endcase
        case (ctl.bsel)
            hse_pkg::B_RCH_NODE: raddr_b = rch_node[AW-1:0];
            hse_pkg::B_RCH_BEST: raddr_b = rch_best[AW-1:0];
            hse_pkg::B_IM1:      raddr_b = im1[AW-1:0];
            default:             raddr_b = '0;
        endcase
    end

    // Advance the step counter
    always_comb
    begin
        pc_next  = pc_reg + hse_pkg::STEP_W'(1);
        ret_next = ret_reg;
        case (ctl.cond)
            hse_pkg::C_NEXT:     pc_next = pc_reg + hse_pkg::STEP_W'(1);
            hse_pkg::C_ALWAYS:   pc_next = ctl.target;
            hse_pkg::C_DISPATCH:
            begin
                pc_next = pc_reg;
                if (accept)
                begin
                    if (item.mode == hse_pkg::MODE_REQUEST)
                    begin
                        pc_next = hse_pkg::ST_ROUT;
                    end
                    else if (item.last)
                    begin
                        pc_next = ctl.target;
                    end
                end
            end
            hse_pkg::C_OUTWAIT:  pc_next = slot_free ? ctl.target : pc_reg;
            hse_pkg::C_IZERO:
            begin
                if (i_reg == '0)
                begin
                    pc_next = ctl.target;
                end
            end
            hse_pkg::C_ILEONE:
            begin
                if (i_reg <= CW'(1))
                begin
                    pc_next = ctl.target;
                end
            end
            hse_pkg::C_CALL:
            begin
                ret_next = pc_reg + hse_pkg::STEP_W'(1);
                pc_next  = ctl.target;
            end
            hse_pkg::C_DONE_RET: pc_next = done_reg ? ret_reg : ctl.target;
            default:             pc_next = hse_pkg::ST_IDLE;
        endcase
    end

    // Datapath operations
    always_comb
    begin
        reading_next = reading_reg;
        count_next   = count_reg;
        rdpos_next   = rdpos_reg;
        i_next       = i_reg;
        size_next    = size_reg;
        node_next    = node_reg;
        best_next    = best_reg;
        cur_next     = cur_reg;
        bval_next    = bval_reg;
        done_next    = done_reg;
        empty_next   = empty_reg;
        out_next     = out_reg;
        we           = 1'b0;
        waddr        = '0;
        wdata        = '0;
        out_valid_next = out_valid_reg && !result_ready;
        case (ctl.op)
            hse_pkg::OP_NOP:
            begin
                we = 1'b0;
            end
            hse_pkg::OP_IDLE:
            begin
                if (accept)
                begin
                    if (item.mode == hse_pkg::MODE_LOAD)
                    begin
                        // Store element; a load after reading starts a new set
                        reading_next = 1'b0;
                        rdpos_next   = '0;
                        count_next   = eff_count;
                        if (eff_count < DEPTH_C)
                        begin
                            we         = 1'b1;
                            waddr      = eff_count[AW-1:0];
                            wdata      = item.value;
                            count_next = eff_count + CW'(1);
                        end
                    end
                    else
                    begin
                        empty_next = !(reading_reg && (rdpos_reg < count_reg));
                    end
                end
            end
            hse_pkg::OP_REQ_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (empty_reg)
                    begin
                        out_next.value_res = '0;
                        out_next.last_res  = 1'b0;
                        out_next.status    = hse_pkg::STATUS_EMPTY;
                    end
                    else
                    begin
                        out_next.value_res = rdata_a;
                        out_next.last_res  = (rdpos_inc == count_reg);
                        out_next.status    = hse_pkg::STATUS_OK;
                        rdpos_next         = rdpos_inc;
                    end
                end
            end
            hse_pkg::OP_BUILD_INIT:
            begin
                size_next = count_reg;
                i_next    = count_reg >> 1;
            end
            hse_pkg::OP_BUILD_STEP:
            begin
                if (i_reg != '0)
                begin
                    i_next    = im1;
                    node_next = im1[AW-1:0];
                end
            end
            hse_pkg::OP_SIFT_CUR:
            begin
                cur_next = rdata_a;
            end
            hse_pkg::OP_SIFT_CMP:
            begin
                done_next = !take_l && !take_r;
                bval_next = take_r ? rdata_b : rdata_a;
                best_next = take_r ? rch_node[AW-1:0] :
                            (take_l ? lch_node[AW-1:0] : node_reg);
            end
            hse_pkg::OP_SIFT_MOVE:
            begin
                // Pull the larger child up, or drop the held value into the hole
                we        = 1'b1;
                waddr     = node_reg;
                wdata     = done_reg ? cur_reg : bval_reg;
                node_next = best_reg;
            end
            hse_pkg::OP_EXTRACT_INIT:
            begin
                i_next = size_reg;
            end
            hse_pkg::OP_EXTRACT_STEP:
            begin
                i_next    = im1;
                size_next = im1;
                node_next = '0;
            end
            hse_pkg::OP_EXTRACT_SWAP:
            begin
                // Move root to the end; the old last element sifts from the root
                we       = 1'b1;
                waddr    = i_reg[AW-1:0];
                wdata    = rdata_a;
                cur_next = rdata_b;
            end
            hse_pkg::OP_SORT_DONE:
            begin
                reading_next = 1'b1;
                rdpos_next   = '0;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= hse_pkg::ST_IDLE;
            ret_reg       <= hse_pkg::ST_IDLE;
            reading_reg   <= 1'b0;
            count_reg     <= '0;
            rdpos_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            ret_reg       <= ret_next;
            reading_reg   <= reading_next;
            count_reg     <= count_next;
            rdpos_reg     <= rdpos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold datapath values
    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        size_reg  <= size_next;
        node_reg  <= node_next;
        best_reg  <= best_next;
        cur_reg   <= cur_next;
        bval_reg  <= bval_next;
        done_reg  <= done_next;
        empty_reg <= empty_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire
